// File: hdl/sfd_pkg.sv
`default_nettype none

package sfd_pkg;

    // Register file layout
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 17;
    localparam int unsigned LEN_W       = 17;
    localparam int unsigned GAIN_W      = 16;
    localparam int unsigned CHAN_W      = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_LENGTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FEEDBACK_GAIN = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WET_GAIN      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DRY_GAIN      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 3'd4;

    // Register reset values
    localparam logic [LEN_W-1:0]  RST_DELAY_LENGTH  = 17'd7200;
    localparam logic [GAIN_W-1:0] RST_FEEDBACK_GAIN = 16'd16423;
    localparam logic [GAIN_W-1:0] RST_WET_GAIN      = 16'd9830;
    localparam logic [GAIN_W-1:0] RST_DRY_GAIN      = 16'd22938;
    localparam logic [CHAN_W-1:0] RST_CHANNEL_COUNT = 2'd2;
    localparam logic [CHAN_W-1:0] CHAN_MONO         = 2'd1;

    // Unsigned Q1.15 gain arithmetic, round half up
    localparam int Q_FRAC     = 15;
    localparam int ROUND_HALF = 16384;

    typedef struct packed {
        logic [GAIN_W-1:0] feedback;
        logic [GAIN_W-1:0] wet;
        logic [GAIN_W-1:0] dry;
    } t_gains;

    // Pipeline control from the position logic to each channel datapath
    typedef struct packed {
        logic s1_hit;   // entry read in stage 1 has been written before
        logic s1_fwd;   // take stage 1 delayed sample from the last writeback
        logic s2_vld;   // stage 2 holds a frame
        logic wr_en;    // write stage 2 result back this cycle
    } t_pipe_ctl;

endpackage

`default_nettype wire

// File: hdl/stereo_feedback_delay_core.sv
// Pipeline: a result beat passes the stage 1, stage 2 and output registers.
// Throughput: one frame per cycle while the output is not stalled; with an
//   effective delay length of one, a frame is held while the previous frame is in stage 1.
// Each line is one RAM with a registered read: read, multiply, sum, write back.
// Reset: registers to defaults, position zero; a fill count makes unwritten
//   entries read as zero, so no clearing pass is needed.
`default_nettype none

module stereo_feedback_delay_core #(
    parameter int MAX_DELAY    = 65536,
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // tdata: left_sample, right_sample
    input  wire logic                                  i_s_axis_tvalid,
    output logic                                       o_s_axis_tready,
    input  wire logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]   i_s_axis_tdata,
    // tdata: left_out, right_out
    output logic                                       o_m_axis_tvalid,
    input  wire logic                                  i_m_axis_tready,
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]        o_m_axis_tdata,
    input  wire logic                                  i_cfg_we,
    input  wire logic [sfd_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  wire logic [sfd_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int DW = ((2*SAMPLE_WIDTH+7)/8)*8;
    localparam int AW = $clog2(MAX_DELAY);

    logic [sfd_pkg::LEN_W-1:0]  r_delay_length;
    logic [sfd_pkg::GAIN_W-1:0] r_feedback_gain, r_wet_gain, r_dry_gain;
    logic [sfd_pkg::CHAN_W-1:0] r_channel_count;

    logic                 r_out_vld;
    logic signed [SW-1:0] r_out_l, r_out_r;

    logic                 adv, accept, ready, mono;
    logic [AW-1:0]        rd_idx, wr_idx;
    logic signed [SW-1:0] y_l, y_r;
    sfd_pkg::t_pipe_ctl   ctl;
    sfd_pkg::t_gains      gains;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_length  <= sfd_pkg::RST_DELAY_LENGTH;
            r_feedback_gain <= sfd_pkg::RST_FEEDBACK_GAIN;
            r_wet_gain      <= sfd_pkg::RST_WET_GAIN;
            r_dry_gain      <= sfd_pkg::RST_DRY_GAIN;
            r_channel_count <= sfd_pkg::RST_CHANNEL_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sfd_pkg::CFG_DELAY_LENGTH:  r_delay_length  <= i_cfg_data;
                sfd_pkg::CFG_FEEDBACK_GAIN: r_feedback_gain <= i_cfg_data[sfd_pkg::GAIN_W-1:0];
                sfd_pkg::CFG_WET_GAIN:      r_wet_gain      <= i_cfg_data[sfd_pkg::GAIN_W-1:0];
                sfd_pkg::CFG_DRY_GAIN:      r_dry_gain      <= i_cfg_data[sfd_pkg::GAIN_W-1:0];
                sfd_pkg::CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[sfd_pkg::CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        gains.feedback = r_feedback_gain;
        gains.wet      = r_wet_gain;
        gains.dry      = r_dry_gain;
        mono           = (r_channel_count == sfd_pkg::CHAN_MONO);
    end

    // Pipeline moves whenever the output register can take a beat
    assign adv             = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = ready;
    assign accept          = i_s_axis_tvalid && ready;

    sfd_ctrl #(
        .MAX_DELAY (MAX_DELAY)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv),
        .i_accept       (accept),
        .i_delay_length (r_delay_length),
        .o_ready        (ready),
        .o_rd_idx       (rd_idx),
        .o_wr_idx       (wr_idx),
        .o_ctl          (ctl)
    );

    sfd_chan #(
        .MAX_DELAY    (MAX_DELAY),
        .SAMPLE_WIDTH (SW)
    ) u_left (
        .i_clk    (i_clk),
        .i_adv    (adv),
        .i_ctl    (ctl),
        .i_rd_idx (rd_idx),
        .i_wr_idx (wr_idx),
        .i_x      ($signed(i_s_axis_tdata[SW-1:0])),
        .i_keep   (1'b0),
        .i_gains  (gains),
        .o_y      (y_l)
    );

    // Right line rewrites its own contents in mono
    sfd_chan #(
        .MAX_DELAY    (MAX_DELAY),
        .SAMPLE_WIDTH (SW)
    ) u_right (
        .i_clk    (i_clk),
        .i_adv    (adv),
        .i_ctl    (ctl),
        .i_rd_idx (rd_idx),
        .i_wr_idx (wr_idx),
        .i_x      ($signed(i_s_axis_tdata[2*SW-1:SW])),
        .i_keep   (mono),
        .i_gains  (gains),
        .o_y      (y_r)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= ctl.s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_l <= y_l;
            r_out_r <= mono ? '0 : y_r;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = DW'({r_out_r, r_out_l});

endmodule

`default_nettype wire

// File: hdl/sfd_ram.sv
`default_nettype none

module sfd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read ports; read returns old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hdl/sfd_ctrl.sv
`default_nettype none

module sfd_ctrl #(
    parameter int MAX_DELAY = 65536
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_adv,
    input  wire logic                         i_accept,
    input  wire logic [sfd_pkg::LEN_W-1:0]    i_delay_length,
    output logic                              o_ready,
    output logic [$clog2(MAX_DELAY)-1:0]      o_rd_idx,
    output logic [$clog2(MAX_DELAY)-1:0]      o_wr_idx,
    output sfd_pkg::t_pipe_ctl                o_ctl
);

    localparam int AW = $clog2(MAX_DELAY);
    localparam int LW = $clog2(MAX_DELAY + 1);
    localparam int CW = (LW > sfd_pkg::LEN_W) ? LW : sfd_pkg::LEN_W;

    logic [AW-1:0] r_pos, n_pos;
    logic [AW:0]   r_fill, n_fill;
    logic          r_s1_vld, r_s1_hit, r_s2_vld, r_fw_vld;
    logic [AW-1:0] r_s1_idx, r_s2_idx, r_fw_idx;

    logic [CW-1:0] len_raw, len, idx_inc;
    logic [AW-1:0] idx;
    logic          hit, hazard;

    // Clamp length to 1..MAX_DELAY and pick the entry for this frame
    always_comb begin
        len_raw = CW'(i_delay_length);
        if (len_raw == '0) begin
            len = CW'(1);
        end else if (len_raw > CW'(MAX_DELAY)) begin
            len = CW'(MAX_DELAY);
        end else begin
            len = len_raw;
        end
        idx     = (CW'(r_pos) < len) ? r_pos : '0;
        idx_inc = CW'(idx) + CW'(1);
        n_pos   = (idx_inc >= len) ? '0 : idx_inc[AW-1:0];
        hit     = ({1'b0, idx} < r_fill);
        n_fill  = ({1'b0, idx} == r_fill) ? r_fill + 1'b1 : r_fill;
        // Hold a frame that reads the entry still being updated in stage 1
        hazard  = r_s1_vld && (r_s1_idx == idx);
    end

    assign o_ready  = i_adv && !hazard;
    assign o_rd_idx = idx;
    assign o_wr_idx = r_s2_idx;

    // Position and fill count advance per accepted frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_fill <= '0;
        end else if (i_accept) begin
            r_pos  <= n_pos;
            r_fill <= n_fill;
        end
    end

    // Stage valids and the last writeback tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_fw_vld <= 1'b0;
        end else if (i_adv) begin
            r_s1_vld <= i_accept;
            r_s2_vld <= r_s1_vld;
            if (r_s2_vld) begin
                r_fw_vld <= 1'b1;
            end
        end
    end

    // Stage indexes
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_idx <= idx;
            r_s1_hit <= hit;
            r_s2_idx <= r_s1_idx;
            if (r_s2_vld) begin
                r_fw_idx <= r_s2_idx;
            end
        end
    end

    always_comb begin
        o_ctl.s1_hit = r_s1_hit;
        o_ctl.s1_fwd = r_fw_vld && (r_fw_idx == r_s1_idx);
        o_ctl.s2_vld = r_s2_vld;
        o_ctl.wr_en  = i_adv && r_s2_vld;
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= (AW+1)'(MAX_DELAY))
        else $error("fill count beyond line depth");

    a_idx_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, idx} <= r_fill)
        else $error("read entry beyond the written prefix");

    a_no_hazard_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |-> !(r_s1_vld && (r_s1_idx == idx)))
        else $error("frame accepted over a pending update of its entry");

    a_adjacent_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s2_vld) |-> (r_s1_idx != r_s2_idx))
        else $error("adjacent stages hold the same entry");

endmodule

`default_nettype wire

// File: hdl/sfd_chan.sv
`default_nettype none

module sfd_chan #(
    parameter int MAX_DELAY    = 65536,
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_adv,
    input  wire sfd_pkg::t_pipe_ctl              i_ctl,
    input  wire logic [$clog2(MAX_DELAY)-1:0]    i_rd_idx,
    input  wire logic [$clog2(MAX_DELAY)-1:0]    i_wr_idx,
    input  wire logic signed [SAMPLE_WIDTH-1:0]  i_x,
    input  wire logic                            i_keep,
    input  wire sfd_pkg::t_gains                 i_gains,
    output logic signed [SAMPLE_WIDTH-1:0]       o_y
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int PW   = SW + 17;
    localparam int SUMW = SW + 19;
    localparam logic signed [SUMW-1:0] RND = SUMW'(sfd_pkg::ROUND_HALF);

    logic [SW-1:0]          ram_q;
    logic [SW-1:0]          wdata;
    logic signed [SW-1:0]   r1_x, r2_x, r2_d, r_fw_data, d;
    logic signed [PW-1:0]   r2_pd, r2_pw, r2_pf;
    logic signed [SUMW-1:0] y_sum, y_sh, f_sh, w_sum;

    function automatic logic [SW-1:0] sat(input logic signed [SUMW-1:0] v);
        logic ovf;
        begin
            ovf = (v[SUMW-1:SW-1] != {(SUMW-SW+1){v[SUMW-1]}});
            if (!ovf) begin
                sat = v[SW-1:0];
            end else if (v[SUMW-1]) begin
                sat = {1'b1, {(SW-1){1'b0}}};
            end else begin
                sat = {1'b0, {(SW-1){1'b1}}};
            end
        end
    endfunction

    sfd_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_DELAY)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (i_ctl.wr_en),
        .i_waddr (i_wr_idx),
        .i_wdata (wdata),
        .i_re    (i_adv),
        .i_raddr (i_rd_idx),
        .o_rdata (ram_q)
    );

    // Delayed sample: last writeback, stored entry, or zero if never written
    always_comb begin
        if (i_ctl.s1_fwd) begin
            d = r_fw_data;
        end else if (i_ctl.s1_hit) begin
            d = $signed(ram_q);
        end else begin
            d = '0;
        end
    end

    // Stage 1: hold input, form the three gain products
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_x  <= i_x;
            r2_x  <= r1_x;
            r2_d  <= d;
            r2_pd <= $signed({1'b0, i_gains.dry}) * r1_x;
            r2_pw <= $signed({1'b0, i_gains.wet}) * d;
            r2_pf <= $signed({1'b0, i_gains.feedback}) * d;
        end
    end

    // Stage 2: round, sum and saturate output and writeback; keep writes back the delayed sample
    always_comb begin
        y_sum = SUMW'(r2_pd) + SUMW'(r2_pw) + RND;
        y_sh  = y_sum >>> sfd_pkg::Q_FRAC;
        f_sh  = (SUMW'(r2_pf) + RND) >>> sfd_pkg::Q_FRAC;
        w_sum = SUMW'(r2_x) + f_sh;
        wdata = i_keep ? r2_d : sat(w_sum);
        o_y   = $signed(sat(y_sh));
    end

    // Keep the latest writeback for a read that raced it
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_fw_data <= $signed(wdata);
        end
    end

endmodule

`default_nettype wire

// File: tb/sv/stereo_feedback_delay_core_tb.sv
`default_nettype none

module stereo_feedback_delay_core_tb;

    localparam int SW          = 24;
    localparam int DEPTH       = 65536;
    localparam int DW          = ((2*SW+7)/8)*8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX  = 10;

    localparam logic [sfd_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [sfd_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_HI = 3'd7;

    localparam logic [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam longint CLIP_HI = (64'sd1 <<< (SW-1)) - 1;
    localparam longint CLIP_LO = -CLIP_HI - 1;

    // Echo predictor: both delay lines, the shared position and the register copies
    class echo_scoreboard;
        int          left_mem[DEPTH];
        int          right_mem[DEPTH];
        int unsigned position;
        int unsigned len_reg;
        int unsigned fb_reg;
        int unsigned wet_reg;
        int unsigned dry_reg;
        int unsigned chan_reg;
        logic [DW-1:0] mix_q[$];
        int          mismatches;

        function new();
            position   = 0;
            len_reg    = 32'(sfd_pkg::RST_DELAY_LENGTH);
            fb_reg     = 32'(sfd_pkg::RST_FEEDBACK_GAIN);
            wet_reg    = 32'(sfd_pkg::RST_WET_GAIN);
            dry_reg    = 32'(sfd_pkg::RST_DRY_GAIN);
            chan_reg   = 32'(sfd_pkg::RST_CHANNEL_COUNT);
            mismatches = 0;
        endfunction

        function void set_reg(logic [sfd_pkg::CFG_INDEX_W-1:0] idx,
                              logic [sfd_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                sfd_pkg::CFG_DELAY_LENGTH:  len_reg  = 32'(data[sfd_pkg::LEN_W-1:0]);
                sfd_pkg::CFG_FEEDBACK_GAIN: fb_reg   = 32'(data[sfd_pkg::GAIN_W-1:0]);
                sfd_pkg::CFG_WET_GAIN:      wet_reg  = 32'(data[sfd_pkg::GAIN_W-1:0]);
                sfd_pkg::CFG_DRY_GAIN:      dry_reg  = 32'(data[sfd_pkg::GAIN_W-1:0]);
                sfd_pkg::CFG_CHANNEL_COUNT: chan_reg = 32'(data[sfd_pkg::CHAN_W-1:0]);
                default: ;
            endcase
        endfunction

        function longint clip(longint v);
            if (v > CLIP_HI) return CLIP_HI;
            if (v < CLIP_LO) return CLIP_LO;
            return v;
        endfunction

        // Round half up out of Q15: floor((v + half) / 2^15)
        function longint q15_round(longint v);
            return (v + sfd_pkg::ROUND_HALF) >>> sfd_pkg::Q_FRAC;
        endfunction

        // Read the tap, mix, and write input plus feedback back to the same entry
        function longint echo_tap(bit right_ch, int unsigned idx, longint x);
            longint d;
            longint y;
            longint w;
            d = longint'(right_ch ? right_mem[idx] : left_mem[idx]);
            y = q15_round(longint'(dry_reg) * x + longint'(wet_reg) * d);
            w = x + q15_round(longint'(fb_reg) * d);
            if (right_ch) right_mem[idx] = int'(clip(w));
            else          left_mem[idx]  = int'(clip(w));
            return clip(y);
        endfunction

        function void note_frame(logic [DW-1:0] beat);
            int unsigned eff_len;
            int unsigned idx;
            longint      lo;
            longint      ro;
            eff_len = len_reg;
            if (eff_len < 1) eff_len = 1;
            if (eff_len > DEPTH) eff_len = DEPTH;
            // Restart from entry 0 when the position lies beyond a shortened line
            idx = (position < eff_len) ? position : 0;
            lo = echo_tap(1'b0, idx, longint'($signed(beat[SW-1:0])));
            ro = 0;
            if (chan_reg != 32'(sfd_pkg::CHAN_MONO))
                ro = echo_tap(1'b1, idx, longint'($signed(beat[2*SW-1:SW])));
            position = (idx + 1 >= eff_len) ? 0 : idx + 1;
            mix_q.push_back(DW'({ro[SW-1:0], lo[SW-1:0]}));
        endfunction

        function void check_frame(logic [DW-1:0] beat);
            logic [DW-1:0] want;
            if (mix_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected output beat %h", beat);
                return;
            end
            want = mix_q.pop_front();
            if (want[SW-1:0] !== beat[SW-1:0] || want[2*SW-1:SW] !== beat[2*SW-1:SW]) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("mismatch: left exp %0d got %0d, right exp %0d got %0d",
                             $signed(want[SW-1:0]), $signed(beat[SW-1:0]),
                             $signed(want[2*SW-1:SW]), $signed(beat[2*SW-1:SW]));
            end
        endfunction

        function int pending();
            return mix_q.size();
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic [DW-1:0]                   s_tdata = '0;
    logic                            m_tready = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [sfd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [sfd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    wire                             o_s_axis_tready;
    wire                             o_m_axis_tvalid;
    wire  [DW-1:0]                   o_m_axis_tdata;

    echo_scoreboard sb = new();

    int cycles = 0;
    int rx_mode = 0;
    int rx_mode_left = 0;
    int rx_hold = 0;

    always #5 i_clk = ~i_clk;

    stereo_feedback_delay_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        // tdata: left_sample, right_sample
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        // tdata: left_out, right_out
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // Stall the output side: tready modes switch at random
    always @(posedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      <= $urandom_range(0, 3);
            rx_mode_left <= $urandom_range(20, 200);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 0);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: begin
                // Hold off for long stretches now and then
                if (rx_hold > 0) begin
                    rx_hold  <= rx_hold - 1;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 7) == 0) rx_hold <= $urandom_range(1, 20);
                end
            end
        endcase
    end

    // Check every output beat taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_tready) sb.check_frame(o_m_axis_tdata);
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [SW-1:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return SW'($urandom_range(0, 255) - 128);
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic int unsigned random_length();
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return 1;
            2:       return DEPTH;
            3:       return $urandom_range(DEPTH + 1, (1 << sfd_pkg::LEN_W) - 1);
            4:       return $urandom_range(301, DEPTH - 1);
            5, 6, 7, 8, 9, 10, 11, 12: return $urandom_range(2, 8);
            default: return $urandom_range(9, 300);
        endcase
    endfunction

    function automatic int unsigned random_gain();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 32768;
            2:       return (1 << sfd_pkg::GAIN_W) - 1;
            3:       return $urandom_range(32769, (1 << sfd_pkg::GAIN_W) - 1);
            default: return $urandom_range(0, 32768);
        endcase
    endfunction

    // Keep the low register bits, fill the rest of the write word with noise
    function automatic logic [sfd_pkg::CFG_DATA_W-1:0] with_noise(int unsigned v, int w);
        logic [sfd_pkg::CFG_DATA_W-1:0] mask;
        mask = sfd_pkg::CFG_DATA_W'((1 << w) - 1);
        return (sfd_pkg::CFG_DATA_W'($urandom) & ~mask) | (sfd_pkg::CFG_DATA_W'(v) & mask);
    endfunction

    // Present one input beat and hold it until taken
    task automatic send_frame(logic [DW-1:0] beat);
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_frame(beat);
    endtask

    // Send random frames in bursts with random gaps
    task automatic run_items(int count);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 32);
            for (int k = 0; k < burst && sent < count; k++) begin
                send_frame(DW'({random_sample(), random_sample()}));
                sent++;
            end
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                s_tdata  <= DW'({$urandom, $urandom});
                repeat (gap) @(posedge i_clk);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    // Wait until every expected beat is out, then let the pipeline settle
    task automatic wait_for_quiet();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [sfd_pkg::CFG_INDEX_W-1:0] idx,
                             logic [sfd_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic apply_settings(int unsigned len, int unsigned fb, int unsigned wet,
                                  int unsigned dry, int unsigned chan);
        write_reg(sfd_pkg::CFG_DELAY_LENGTH, sfd_pkg::CFG_DATA_W'(len));
        write_reg(sfd_pkg::CFG_FEEDBACK_GAIN, with_noise(fb, sfd_pkg::GAIN_W));
        write_reg(sfd_pkg::CFG_WET_GAIN, with_noise(wet, sfd_pkg::GAIN_W));
        write_reg(sfd_pkg::CFG_DRY_GAIN, with_noise(dry, sfd_pkg::GAIN_W));
        write_reg(sfd_pkg::CFG_CHANNEL_COUNT, with_noise(chan, sfd_pkg::CHAN_W));
        // Poke an unmapped index now and then; it must change nothing
        if ($urandom_range(0, 2) == 0)
            write_reg(sfd_pkg::CFG_INDEX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)),
                      sfd_pkg::CFG_DATA_W'($urandom));
        cfg_we    <= 1'b0;
        cfg_index <= sfd_pkg::CFG_INDEX_W'($urandom);
        cfg_data  <= sfd_pkg::CFG_DATA_W'($urandom);
        @(posedge i_clk);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings, sample extremes
        send_frame({SW'(0), SW'(0)});
        send_frame({SAMPLE_MIN, SAMPLE_MAX});
        send_frame({SAMPLE_MAX, SAMPLE_MIN});
        send_frame({SW'(1), {SW{1'b1}}});
        s_tvalid <= 1'b0;
        wait_for_quiet();

        // Length one back to back, full-scale gains, saturation on both paths
        apply_settings(1, (1 << sfd_pkg::GAIN_W) - 1, (1 << sfd_pkg::GAIN_W) - 1,
                       (1 << sfd_pkg::GAIN_W) - 1, 3);
        send_frame({SAMPLE_MAX, SAMPLE_MAX});
        send_frame({SAMPLE_MIN, SAMPLE_MAX});
        send_frame({SAMPLE_MIN, SAMPLE_MIN});
        send_frame({{SW{1'b1}}, SW'(1)});
        send_frame({SW'(0), SW'(0)});
        s_tvalid <= 1'b0;
        wait_for_quiet();

        // Length zero floors to one; mono drops the right channel
        apply_settings(0, 32768, 32768, 0, 32'(sfd_pkg::CHAN_MONO));
        send_frame({SAMPLE_MAX, SW'(100)});
        send_frame({SAMPLE_MIN, -SW'(100)});
        send_frame({SW'(5), SAMPLE_MIN});
        s_tvalid <= 1'b0;
        wait_for_quiet();

        // Length beyond the line saturates; channel count zero is stereo
        apply_settings((1 << sfd_pkg::LEN_W) - 1, 0, 0, 32768, 0);
        send_frame({SW'(7), SAMPLE_MAX});
        send_frame({SAMPLE_MIN, SW'(9)});
        send_frame({SW'(3), SW'(-3)});
        s_tvalid <= 1'b0;
        wait_for_quiet();

        // Shorten below the current position; old contents stay in place
        apply_settings(3, 20000, 12000, 25000, 2);
        write_reg(CFG_UNUSED_LO, '1);
        write_reg(CFG_UNUSED_HI, '1);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        send_frame({SW'(1000), SW'(-1000)});
        send_frame({SAMPLE_MAX, SAMPLE_MIN});
        send_frame({SW'(0), SW'(0)});
        send_frame({SW'(-1), SW'(1)});
        send_frame({SW'(0), SW'(0)});
        s_tvalid <= 1'b0;
        wait_for_quiet();

        // Random phases, each with fresh settings
        for (int p = 0; p < 10; p++) begin
            apply_settings(random_length(), random_gain(), random_gain(), random_gain(),
                           $urandom_range(0, 3));
            run_items($urandom_range(150, 250));
            wait_for_quiet();
        end

        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
